// ===== src/xpl_pkg.sv =====
// Shared types, codes and constants of the xPL message field parser.
package xpl_pkg;

    typedef enum logic [3:0] {
        MODE_SECTION = 4'b0001,
        MODE_NAME    = 4'b0010,
        MODE_VALUE   = 4'b0100,
        MODE_AFTER   = 4'b1000
    } mode_t;

    localparam logic [2:0] KIND_TYPE   = 3'd0;
    localparam logic [2:0] KIND_SCHEMA = 3'd1;
    localparam logic [2:0] KIND_SOURCE = 3'd2;
    localparam logic [2:0] KIND_TARGET = 3'd3;
    localparam logic [2:0] KIND_BNAME  = 3'd4;
    localparam logic [2:0] KIND_BVALUE = 3'd5;

    localparam logic [2:0] VDEST_NONE  = 3'd0;

    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_EQ     = 8'h3D;
    localparam logic [7:0] CHAR_BANG   = 8'h21;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;

    localparam logic [7:0] KEY_LEN     = 8'd6;

    typedef struct packed {
        mode_t      mode;
        logic [1:0] skip;
        logic [7:0] tlen;
        logic [1:0] sect;
        logic       src_match;
        logic       tgt_match;
        logic [2:0] vdest;
    } parse_state_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
        logic [7:0] char_val;
        logic       fend;
    } field_word_t;

    localparam parse_state_t STATE_RESET = '{
        mode:      MODE_SECTION,
        skip:      2'd0,
        tlen:      8'd0,
        sect:      2'd0,
        src_match: 1'b1,
        tgt_match: 1'b1,
        vdest:     VDEST_NONE
    };

    function automatic logic [7:0] source_char(input logic [2:0] pos);
        logic [7:0] r;
        case (pos)
            3'd0:    r = "s";
            3'd1:    r = "o";
            3'd2:    r = "u";
            3'd3:    r = "r";
            3'd4:    r = "c";
            3'd5:    r = "e";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] target_char(input logic [2:0] pos);
        logic [7:0] r;
        case (pos)
            3'd0:    r = "t";
            3'd1:    r = "a";
            3'd2:    r = "r";
            3'd3:    r = "g";
            3'd4:    r = "e";
            3'd5:    r = "t";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ===== src/xpl_if.sv =====
// Valid/ready channel interfaces for message bytes and field words.
interface xpl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       first;

    modport source (output valid, output ch, output first, input ready);
    modport sink   (input valid, input ch, input first, output ready);
endinterface

interface xpl_field_if;
    logic       valid;
    logic       ready;
    logic [2:0] field_kind;
    logic [7:0] out_char;
    logic       field_end;

    modport source (output valid, output field_kind, output out_char, output field_end,
                     input ready);
    modport sink   (input valid, input field_kind, input out_char, input field_end,
                    output ready);
endinterface

// ===== src/xpl_step.sv =====
// Next-state and field word logic for one message byte.
module xpl_step #(
    parameter int SECTION_LIMIT = 34,
    parameter int NAME_LIMIT    = 16,
    parameter int VALUE_LIMIT   = 128
) (
    input  xpl_pkg::parse_state_t cur,
    input  logic [7:0]            ch,
    input  logic                  first,
    output xpl_pkg::parse_state_t nxt,
    output xpl_pkg::field_word_t  word
);
    import xpl_pkg::*;

    localparam logic [7:0] SEC_LIM = 8'(SECTION_LIMIT);
    localparam logic [7:0] NAM_LIM = 8'(NAME_LIMIT);
    localparam logic [7:0] VAL_LIM = 8'(VALUE_LIMIT);

    function automatic void name_byte(input logic [7:0] c, inout parse_state_t s,
                                      inout field_word_t w);
        logic in_key;
        logic is_src;
        logic is_tgt;
        in_key = (s.tlen < KEY_LEN);
        if (c != CHAR_EQ && c != CHAR_BANG && s.tlen != NAM_LIM) begin
            if (!in_key || source_char(s.tlen[2:0]) != c) s.src_match = 1'b0;
            if (!in_key || target_char(s.tlen[2:0]) != c) s.tgt_match = 1'b0;
            s.tlen = s.tlen + 8'd1;
            if (s.sect == 2'd2) w = '{valid: 1'b1, kind: KIND_BNAME, char_val: c, fend: 1'b0};
        end
        else begin
            is_src = (s.tlen == KEY_LEN) && s.src_match;
            is_tgt = (s.tlen == KEY_LEN) && s.tgt_match;
            s.vdest = VDEST_NONE;
            if (s.sect == 2'd1) begin
                if (is_src) s.vdest = KIND_SOURCE + 3'd1;
                else if (is_tgt) s.vdest = KIND_TARGET + 3'd1;
            end
            else if (s.sect == 2'd2) begin
                s.vdest = KIND_BVALUE + 3'd1;
            end
            s.mode      = MODE_VALUE;
            s.tlen      = 8'd0;
            s.src_match = 1'b1;
            s.tgt_match = 1'b1;
            if (s.sect == 2'd2) w = '{valid: 1'b1, kind: KIND_BNAME, char_val: 8'h00, fend: 1'b1};
        end
    endfunction

    always_comb
    begin
        parse_state_t s;
        field_word_t  w;
        s = first ? STATE_RESET : cur;
        w = '{valid: 1'b0, kind: KIND_TYPE, char_val: 8'h00, fend: 1'b0};
        if (s.skip != 2'd0) begin
            s.skip = s.skip - 2'd1;
        end
        else begin
            unique case (s.mode)
                MODE_SECTION:
                begin
                    if (ch != CHAR_LF && s.tlen != SEC_LIM) begin
                        s.tlen = s.tlen + 8'd1;
                        if (s.sect < 2'd2)
                            w = '{valid: 1'b1, kind: {1'b0, s.sect}, char_val: ch, fend: 1'b0};
                    end
                    else begin
                        if (s.sect < 2'd2)
                            w = '{valid: 1'b1, kind: {1'b0, s.sect}, char_val: 8'h00,
                                  fend: 1'b1};
                        if (s.sect < 2'd3) s.sect = s.sect + 2'd1;
                        s.mode      = MODE_NAME;
                        s.skip      = 2'd2;
                        s.tlen      = 8'd0;
                        s.src_match = 1'b1;
                        s.tgt_match = 1'b1;
                    end
                end
                MODE_NAME:
                begin
                    name_byte(ch, s, w);
                end
                MODE_VALUE:
                begin
                    if (ch != CHAR_LF && s.tlen != VAL_LIM) begin
                        s.tlen = s.tlen + 8'd1;
                        if (s.vdest != VDEST_NONE)
                            w = '{valid: 1'b1, kind: s.vdest - 3'd1, char_val: ch, fend: 1'b0};
                    end
                    else begin
                        if (s.vdest != VDEST_NONE)
                            w = '{valid: 1'b1, kind: s.vdest - 3'd1, char_val: 8'h00,
                                  fend: 1'b1};
                        s.vdest = VDEST_NONE;
                        s.tlen  = 8'd0;
                        s.mode  = MODE_AFTER;
                    end
                end
                MODE_AFTER:
                begin
                    if (ch == CHAR_RBRACE) begin
                        s.mode = MODE_SECTION;
                        s.skip = 2'd1;
                        s.tlen = 8'd0;
                    end
                    else begin
                        s.mode      = MODE_NAME;
                        s.tlen      = 8'd0;
                        s.src_match = 1'b1;
                        s.tgt_match = 1'b1;
                        name_byte(ch, s, w);
                    end
                end
                default:
                begin
                    s = STATE_RESET;
                end
            endcase
        end
        nxt  = s;
        word = w;
    end

endmodule

// ===== src/xpl_message_field_parser.sv =====
// Top level: byte input register, parser state and field word output register.
// A taken byte is held in the input register until its word enters the output register.
// Throughput: one byte per cycle unless the output stalls; state updates in a single step.
// Bytes that are skipped or dropped give no word and do not stall the input.
// Reset: rst_n clears the parser state and the valid flags of both registers at once.
// A byte with first set restarts the parse state before the step handles that byte.
module xpl_message_field_parser #(
    parameter int SECTION_LIMIT = 34,
    parameter int NAME_LIMIT    = 16,
    parameter int VALUE_LIMIT   = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    xpl_byte_if.sink           bytes,
    xpl_field_if.source        fields
);
    import xpl_pkg::*;

    logic         in_v_reg;
    logic         in_v_next;
    logic [7:0]   ch_reg;
    logic         first_reg;
    logic         out_v_reg;
    logic         out_v_next;
    logic [2:0]   kind_reg;
    logic [7:0]   char_reg;
    logic         fend_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t step_state;
    field_word_t  step_word;
    logic         advance;
    logic         take;

    xpl_step #(
        .SECTION_LIMIT (SECTION_LIMIT),
        .NAME_LIMIT    (NAME_LIMIT),
        .VALUE_LIMIT   (VALUE_LIMIT)
    ) u_step (
        .cur   (state_reg),
        .ch    (ch_reg),
        .first (first_reg),
        .nxt   (step_state),
        .word  (step_word)
    );

    assign advance      = !out_v_reg || fields.ready;
    assign bytes.ready  = !in_v_reg || advance;
    assign take         = bytes.valid && bytes.ready;

    always_comb
    begin
        in_v_next  = in_v_reg;
        out_v_next = out_v_reg;
        state_next = state_reg;
        if (advance) begin
            out_v_next = in_v_reg && step_word.valid;
            in_v_next  = 1'b0;
            if (in_v_reg) state_next = step_state;
        end
        if (take) in_v_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            state_reg <= STATE_RESET;
        end
        else begin
            in_v_reg  <= in_v_next;
            out_v_reg <= out_v_next;
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            ch_reg    <= bytes.ch;
            first_reg <= bytes.first;
        end
        if (advance && in_v_reg) begin
            kind_reg <= step_word.kind;
            char_reg <= step_word.char_val;
            fend_reg <= step_word.fend;
        end
    end

    assign fields.valid      = out_v_reg;
    assign fields.field_kind = kind_reg;
    assign fields.out_char   = char_reg;
    assign fields.field_end  = fend_reg;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !bytes.ready |-> (in_v_reg && out_v_reg && !fields.ready))
        else $error("byte input stalled with free space");

    a_end_has_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && fend_reg) |-> (char_reg == 8'h00))
        else $error("end word carries a character");

    a_kind_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> (kind_reg <= KIND_BVALUE))
        else $error("field kind out of range");

    a_skip_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.skip != 2'd0) |->
            (state_reg.mode == MODE_NAME || state_reg.mode == MODE_SECTION))
        else $error("skip pending outside header or name parsing");

    a_word_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !fields.ready) |=> (out_v_reg && $stable(char_reg)))
        else $error("pending field word lost");
`endif

endmodule
